// ----- rtl/aofp_pkg.sv -----
// aofp_pkg: shared constants, types and helpers for the ascii output frame parser
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package aofp_pkg;

	// frame layout
	localparam int PAYLOAD_LEN_DEF = 12;
	localparam int PAYLOAD_LEN_MAX = 12;
	localparam int SYNC_COUNT      = 3;
	localparam int DIGIT_COUNT     = 3;

	// field widths
	localparam int BYTE_W  = 8;
	localparam int BITS_W  = 12;
	localparam int PHASE_W = 5;
	localparam int SUM_W   = 12;
	localparam int VALUE_W = 16;

	// character codes
	localparam logic [BYTE_W-1:0] SYNC_CHAR = 8'h23;
	localparam logic [BYTE_W-1:0] ZERO_CHAR = 8'h30;

	// checksum digit positions
	localparam logic [1:0] DIGIT_HUNDREDS = 2'd0;
	localparam logic [1:0] DIGIT_TENS     = 2'd1;

	// one received byte with its valid flag
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} aofp_byte_req_t;

	// payload of one parsed frame
	typedef struct packed {
		logic [BITS_W-1:0] out_bits;
		logic              checksum_ok;
	} aofp_result_t;

	// result request from the parser to the output register
	typedef struct packed {
		logic         valid;
		aofp_result_t result;
	} aofp_res_req_t;

	// weight of a checksum digit by position
	function automatic logic [6:0] aofp_digit_weight(input logic [1:0] idx);
		logic [6:0] w;
		unique case (idx)
			DIGIT_HUNDREDS: w = 7'd100;
			DIGIT_TENS:     w = 7'd10;
			default:        w = 7'd1;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/aofp_in_if.sv -----
// aofp_in_if: valid/ready channel carrying one received byte
// depends on aofp_pkg for the byte width
`timescale 1ns / 1ps
`default_nettype none

interface aofp_in_if
	import aofp_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/aofp_out_if.sv -----
// aofp_out_if: valid/ready channel carrying one parsed frame result
// depends on aofp_pkg for the result width
`timescale 1ns / 1ps
`default_nettype none

interface aofp_out_if
	import aofp_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BITS_W-1:0] out_bits;
	logic              checksum_ok;

	modport source (output valid, output out_bits, output checksum_ok, input ready);
	modport sink (input valid, input out_bits, input checksum_ok, output ready);
endinterface

`default_nettype wire

// ----- rtl/ascii_output_frame_parser_core.sv -----
// ascii_output_frame_parser_core: top level of the ascii command frame parser
// depends on aofp_pkg, aofp_in_if, aofp_out_if, aofp_in_stage, aofp_frame_fsm, aofp_out_stage
//
// Usage:
//   rx carries received bytes, one per request. Frames are three '#' bytes, PAYLOAD_LEN
//   payload bytes and three ASCII decimal checksum digits. A byte other than '#' during
//   sync restarts the hunt.
//   res carries one request per frame, issued on its last checksum digit: out_bits holds
//   one bit per payload byte (first byte in the highest used bit), checksum_ok is set
//   when the payload byte sum equals the decimal checksum. Apply out_bits only when ok.
//   Throughput: one byte per cycle, set by the single parse stage between the input
//   register and the result register, except while a final digit waits (see Stall).
//   The last digit goes from the input register through the parse stage into the result
//   register when that register has room; the result register then drives res.valid.
//   Stall: while res is held, bytes keep flowing until a final digit reaches the parse
//   stage; it then waits there and rx.ready drops until the result register frees.
//   Reset (arst_n low): both registers empty, parser back to hunting the first sync byte.
`timescale 1ns / 1ps
`default_nettype none

module ascii_output_frame_parser_core
	import aofp_pkg::*;
#(
	parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	aofp_in_if.sink    rx,
	aofp_out_if.source res
);

	aofp_byte_req_t byte_req;
	aofp_res_req_t  res_req;
	logic           consume;
	logic           res_can_take;

	aofp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.consume  (consume),
		.byte_req (byte_req)
	);

	aofp_frame_fsm #(
		.PAYLOAD_LEN (PAYLOAD_LEN)
	) u_frame_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_req     (byte_req),
		.res_can_take (res_can_take),
		.consume      (consume),
		.res_req      (res_req)
	);

	aofp_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_req      (res_req),
		.res_can_take (res_can_take),
		.res          (res)
	);

endmodule

`default_nettype wire

// ----- rtl/aofp_in_stage.sv -----
// aofp_in_stage: input register in front of the frame parser
// depends on aofp_pkg and aofp_in_if
`timescale 1ns / 1ps
`default_nettype none

module aofp_in_stage
	import aofp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	aofp_in_if.sink        rx,
	input  wire logic      consume,
	output aofp_byte_req_t byte_req
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// take a new request whenever the stage is empty or drains this cycle
	assign rx.ready = !valid_s1 || consume;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// byte register
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign byte_req.valid = valid_s1;
	assign byte_req.data  = byte_s1;

endmodule

`default_nettype wire

// ----- rtl/aofp_frame_fsm.sv -----
// aofp_frame_fsm: frame phase tracking, payload sum, bit collection and checksum
// depends on aofp_pkg
`timescale 1ns / 1ps
`default_nettype none

module aofp_frame_fsm
	import aofp_pkg::*;
#(
	parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire aofp_byte_req_t byte_req,
	input  wire logic           res_can_take,
	output logic                consume,
	output aofp_res_req_t       res_req
);

	localparam logic [PHASE_W-1:0] SYNC_LAST = PHASE_W'(SYNC_COUNT - 1);
	localparam logic [PHASE_W-1:0] PAY_BEG   = PHASE_W'(SYNC_COUNT);
	localparam logic [PHASE_W-1:0] PAY_END   = PHASE_W'(SYNC_COUNT + PAYLOAD_LEN);
	localparam logic [PHASE_W-1:0] LAST      = PHASE_W'(SYNC_COUNT + PAYLOAD_LEN + DIGIT_COUNT - 1);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [SUM_W-1:0]   sum_q, sum_d;
	logic [BITS_W-1:0]  shift_q, shift_d;
	logic [VALUE_W-1:0] value_q, value_d;

	logic               in_sync, in_payload, in_digit, is_last;
	logic [PHASE_W-1:0] digit_off;
	logic [VALUE_W-1:0] digit_val, term;
	logic [BYTE_W-1:0]  b;

	assign b          = byte_req.data;
	assign in_sync    = phase_q < PAY_BEG;
	assign in_payload = !in_sync && (phase_q < PAY_END);
	assign in_digit   = !in_sync && !in_payload && (phase_q <= LAST);
	assign is_last    = phase_q == LAST;

	// a final digit waits while the output register is full
	assign consume = byte_req.valid && (!is_last || res_can_take);

	// weighted checksum digit, modulo 2^16
	assign digit_off = phase_q - PAY_END;
	assign digit_val = {{(VALUE_W-BYTE_W){1'b0}}, b} - {{(VALUE_W-BYTE_W){1'b0}}, ZERO_CHAR};
	assign term      = VALUE_W'(digit_val * VALUE_W'(aofp_digit_weight(digit_off[1:0])));

	// next state for one consumed byte
	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		shift_d = shift_q;
		value_d = value_q;
		priority if (in_sync) begin
			if (b == SYNC_CHAR) begin
				phase_d = phase_q + PHASE_W'(1);
				if (phase_q == SYNC_LAST) begin
					sum_d   = '0;
					shift_d = '0;
					value_d = '0;
				end
			end else begin
				phase_d = '0;
			end
		end else if (in_payload) begin
			sum_d   = sum_q + {{(SUM_W-BYTE_W){1'b0}}, b};
			shift_d = {shift_q[BITS_W-2:0], b != ZERO_CHAR};
			phase_d = phase_q + PHASE_W'(1);
		end else if (in_digit) begin
			value_d = value_q + term;
			phase_d = is_last ? '0 : phase_q + PHASE_W'(1);
		end else begin
			phase_d = '0;
		end
	end

	// phase and accumulator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			sum_q   <= '0;
			shift_q <= '0;
			value_q <= '0;
		end else if (consume) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			shift_q <= shift_d;
			value_q <= value_d;
		end
	end

	// result on the last checksum digit
	assign res_req.valid              = consume && is_last;
	assign res_req.result.out_bits    = shift_q;
	assign res_req.result.checksum_ok = {{(VALUE_W-SUM_W){1'b0}}, sum_q} == value_d;

`ifndef SYNTH
	// a result only comes from a final digit that is present
	a_res_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_req.valid |-> (byte_req.valid && phase_q == LAST))
		else $error("result outside the last checksum phase");

	// after a result the parser hunts the next frame
	a_hunt_after_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_req.valid |=> phase_q == '0)
		else $error("phase not cleared after frame end");

	// third sync byte clears the accumulators
	a_frame_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && phase_q == SYNC_LAST && b == SYNC_CHAR)
		|=> (sum_q == '0 && shift_q == '0 && value_q == '0 && phase_q == PAY_BEG))
		else $error("accumulators not cleared at frame start");

	// a final digit is never dropped while the output is full
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_req.valid && is_last && !res_can_take) |-> !consume)
		else $error("final digit consumed into a full output register");
`endif

endmodule

`default_nettype wire

// ----- rtl/aofp_out_stage.sv -----
// aofp_out_stage: result register driving the output channel
// depends on aofp_pkg and aofp_out_if
`timescale 1ns / 1ps
`default_nettype none

module aofp_out_stage
	import aofp_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire aofp_res_req_t res_req,
	output logic               res_can_take,
	aofp_out_if.source         res
);

	logic         valid_q;
	aofp_result_t result_q;

	// room when empty or when the held request leaves this cycle
	assign res_can_take = !valid_q || res.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_req.valid) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_req.valid) begin
			result_q <= res_req.result;
		end
	end

	assign res.valid       = valid_q;
	assign res.out_bits    = result_q.out_bits;
	assign res.checksum_ok = result_q.checksum_ok;

endmodule

`default_nettype wire

// ----- verif/ascii_output_frame_parser_core_test.sv -----
// ascii_output_frame_parser_core_test: self-checking bench for the ascii command frame parser
// depends on aofp_pkg, aofp_in_if, aofp_out_if and ascii_output_frame_parser_core
// a frame scoreboard tracks every accepted byte and checks each frame result in order
`timescale 1ns / 1ps

// tracks the parse of the byte stream and holds the frame results still owed
class frame_scoreboard;
	localparam int PAY_END    = aofp_pkg::SYNC_COUNT + aofp_pkg::PAYLOAD_LEN_DEF;
	localparam int LAST_DIGIT = PAY_END + aofp_pkg::DIGIT_COUNT - 1;

	aofp_pkg::aofp_result_t           pending_frames[$];
	logic [aofp_pkg::PHASE_W-1:0]     phase;
	logic [aofp_pkg::SUM_W-1:0]       byte_sum;
	logic [aofp_pkg::BITS_W-1:0]      bit_shift;
	logic [aofp_pkg::VALUE_W-1:0]     digit_value;
	int                               mismatches;

	function new();
		phase       = '0;
		byte_sum    = '0;
		bit_shift   = '0;
		digit_value = '0;
		mismatches  = 0;
	endfunction

	task flag_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// advance the parse by one accepted byte
	function void note_byte(input logic [aofp_pkg::BYTE_W-1:0] b);
		int                     weight;
		int                     diff;
		aofp_pkg::aofp_result_t done;
		if (phase < aofp_pkg::SYNC_COUNT) begin
			// sync hunt, any other byte restarts it
			if (b == aofp_pkg::SYNC_CHAR) begin
				phase = phase + 1'b1;
				if (phase == aofp_pkg::SYNC_COUNT) begin
					byte_sum    = '0;
					bit_shift   = '0;
					digit_value = '0;
				end
			end else begin
				phase = '0;
			end
		end else if (phase < PAY_END) begin
			// payload byte: sum and one flag bit
			byte_sum  = byte_sum + b;
			bit_shift = {bit_shift[aofp_pkg::BITS_W-2:0], b != aofp_pkg::ZERO_CHAR};
			phase     = phase + 1'b1;
		end else begin
			// checksum digit, unvalidated
			case (phase - PAY_END)
				0:       weight = 100;
				1:       weight = 10;
				default: weight = 1;
			endcase
			diff        = int'(b) - int'(aofp_pkg::ZERO_CHAR);
			digit_value = digit_value + aofp_pkg::VALUE_W'(diff * weight);
			if (phase == LAST_DIGIT) begin
				done.out_bits    = bit_shift;
				done.checksum_ok = ({4'd0, byte_sum} == digit_value);
				pending_frames.push_back(done);
				phase = '0;
			end else begin
				phase = phase + 1'b1;
			end
		end
	endfunction

	// compare one accepted frame result with the oldest one owed
	task check_result(input aofp_pkg::aofp_result_t got);
		aofp_pkg::aofp_result_t want;
		if (pending_frames.size() == 0) begin
			flag_mismatch($sformatf("unexpected result bits=%h ok=%b",
				got.out_bits, got.checksum_ok));
		end else begin
			want = pending_frames.pop_front();
			if (got.out_bits !== want.out_bits)
				flag_mismatch($sformatf("out_bits got %h want %h",
					got.out_bits, want.out_bits));
			if (got.checksum_ok !== want.checksum_ok)
				flag_mismatch($sformatf("checksum_ok got %b want %b",
					got.checksum_ok, want.checksum_ok));
		end
	endtask
endclass

module ascii_output_frame_parser_core_test;
	import aofp_pkg::*;

	localparam int                CYCLE_LIMIT = 400000;
	localparam int                BYTE_TARGET = 800;
	localparam int                TAIL_START  = 680;
	localparam logic [BYTE_W-1:0] ONE_CHAR    = 8'h31;

	typedef logic [BYTE_W-1:0] payload_t [PAYLOAD_LEN_DEF];

	logic clk;
	logic arst_n;
	int   cycles;
	int   bytes_sent;
	bit   gaps_on;
	bit   quiet_tail;

	logic [BYTE_W-1:0] tx_bytes[$];
	payload_t          pay;
	frame_scoreboard   sb;

	aofp_in_if  rx_ch ();
	aofp_out_if res_ch ();

	ascii_output_frame_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result('{out_bits: res_ch.out_bits, checksum_ok: res_ch.checksum_ok});
			if (rx_ch.valid && rx_ch.ready)
				sb.note_byte(rx_ch.rx_byte);
		end
	end

	// result sink: ready runs and stall bursts; in the tail, always ready after the current run
	initial begin
		int run_left;
		bit cur_ready;
		run_left  = 0;
		cur_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				if (quiet_tail) begin
					cur_ready = 1'b1;
					run_left  = 1;
				end else if ($urandom_range(0, 3) == 0) begin
					cur_ready = 1'b0;
					run_left  = $urandom_range(1, 16);
				end else begin
					cur_ready = 1'b1;
					run_left  = $urandom_range(1, 40);
				end
			end
			res_ch.ready <= cur_ready;
			run_left--;
		end
	end

	// one byte request, entered and left at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (gaps_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
		bytes_sent++;
		quiet_tail = (bytes_sent >= TAIL_START);
	endtask

	task automatic play_stream();
		gaps_on = ($urandom_range(0, 2) != 0);
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	function automatic void add_sync();
		repeat (SYNC_COUNT) tx_bytes.push_back(SYNC_CHAR);
	endfunction

	// decimal digits, the hundreds digit may run past '9' for sums over 999
	function automatic void add_digits(input int value);
		tx_bytes.push_back(BYTE_W'(ZERO_CHAR + value / 100));
		tx_bytes.push_back(BYTE_W'(ZERO_CHAR + (value % 100) / 10));
		tx_bytes.push_back(BYTE_W'(ZERO_CHAR + value % 10));
	endfunction

	function automatic int add_payload(input payload_t p);
		int sum;
		sum = 0;
		foreach (p[i]) begin
			tx_bytes.push_back(p[i]);
			sum += p[i];
		end
		return sum;
	endfunction

	// complete frame with a matching checksum
	function automatic void add_frame(input payload_t p);
		add_sync();
		add_digits(add_payload(p));
	endfunction

	// payload mostly of '0' and '1' with some arbitrary bytes
	function automatic void fill_payload(output payload_t p);
		foreach (p[i]) begin
			if ($urandom_range(0, 1))
				p[i] = $urandom_range(0, 1) ? ONE_CHAR : ZERO_CHAR;
			else
				p[i] = BYTE_W'($urandom_range(0, 255));
		end
	endfunction

	// stimulus and end of run
	initial begin
		int kind;
		int n;
		sb            = new();
		cycles        = 0;
		bytes_sent    = 0;
		gaps_on       = 1'b0;
		quiet_tail    = 1'b0;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all '0' payload, plain digits
		pay = '{default: ZERO_CHAR};
		add_frame(pay);
		// all 0xff payload, largest sum
		pay = '{default: 8'hFF};
		add_frame(pay);
		// all 0x00 payload, zero sum
		pay = '{default: 8'h00};
		add_frame(pay);
		// sync misses on 0x00 and 0xff, then alternating payload
		tx_bytes.push_back(SYNC_CHAR);
		tx_bytes.push_back(SYNC_CHAR);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(SYNC_CHAR);
		tx_bytes.push_back(8'hFF);
		foreach (pay[i]) pay[i] = i[0] ? ONE_CHAR : ZERO_CHAR;
		add_frame(pay);
		// extra sync char slides into the payload
		tx_bytes.push_back(SYNC_CHAR);
		add_frame(pay);
		// bad checksum still gives a result
		fill_payload(pay);
		add_frame(pay);
		tx_bytes[$] = tx_bytes[$] + 8'd1;
		// non-digit checksum bytes with a negative value
		fill_payload(pay);
		add_sync();
		void'(add_payload(pay));
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(8'h2F);
		// non-digit tens byte that still matches: 4*100 + 17*10 + 6 = 576
		pay = '{default: ZERO_CHAR};
		add_sync();
		void'(add_payload(pay));
		tx_bytes.push_back(8'h34);
		tx_bytes.push_back(8'h41);
		tx_bytes.push_back(8'h36);
		play_stream();

		// random part: mostly good frames, some noise and broken ones
		while (bytes_sent < BYTE_TARGET) begin
			kind = $urandom_range(0, 19);
			fill_payload(pay);
			if (kind <= 13) begin
				add_frame(pay);
			end else if (kind <= 15) begin
				add_frame(pay);
				tx_bytes[$] = tx_bytes[$] ^ BYTE_W'($urandom_range(1, 255));
			end else if (kind == 16) begin
				add_frame(pay);
				repeat (DIGIT_COUNT) void'(tx_bytes.pop_back());
				repeat (DIGIT_COUNT) tx_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
			end else if (kind == 17) begin
				n = $urandom_range(1, 5);
				repeat (n) tx_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
			end else if (kind == 18) begin
				n = $urandom_range(1, 2);
				repeat (n) tx_bytes.push_back(SYNC_CHAR);
				tx_bytes.push_back(ZERO_CHAR + BYTE_W'($urandom_range(0, 9)));
			end else begin
				tx_bytes.push_back(SYNC_CHAR);
				add_frame(pay);
			end
			play_stream();
		end
		rx_ch.valid <= 1'b0;

		// drain, then allow for the output latency
		while (sb.pending_frames.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
